// ----- design/byte_cpu_instruction_executor_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Byte CPU instruction executor: assertion macros
// Shared property shapes, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BYTE_CPU_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define BYTE_CPU_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BCIU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BCIU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bciu_pkg.sv -----
// ----------------------------------------------------------------------------
// bciu_pkg
// Types and constants shared by the byte CPU instruction executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bciu_pkg;

  localparam int NUM_REGS     = 64;
  localparam int DATA_DEPTH   = 2048;
  // The load/store address is the 6-bit immediate, so only this span is reachable.
  localparam int IMM_SPAN     = 64;
  localparam int DMEM_ENTRIES = (DATA_DEPTH < IMM_SPAN) ? DATA_DEPTH : IMM_SPAN;
  localparam int REG_AW       = $clog2(NUM_REGS);
  localparam int DMEM_AW      = $clog2(DMEM_ENTRIES);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 56;
  localparam int OUT_TUSER_W  = 4;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_LDI  = 4'd3,
    OP_BEQZ = 4'd4,
    OP_AND  = 4'd5,
    OP_OR   = 4'd6,
    OP_JR   = 4'd7,
    OP_SLC  = 4'd8,
    OP_SRC  = 4'd9,
    OP_LB   = 4'd10,
    OP_SB   = 4'd11
  } op_e;

  // Decoded instruction handed from the front end to the execute side.
  typedef struct packed {
    op_e               op;
    logic              bad;
    logic              reg_wr;
    logic [REG_AW-1:0] r1;
    logic [5:0]        r2_imm;
  } dec_t;

  // One result item.
  typedef struct packed {
    logic [15:0]       next_pc;
    logic [4:0]        status_flags;
    logic              reg_write;
    logic [REG_AW-1:0] reg_index;
    logic signed [7:0] reg_data;
    logic              mem_write;
    logic [5:0]        mem_addr;
    logic signed [7:0] mem_data;
    logic              branch_taken;
    logic              bad_opcode;
  } res_t;

endpackage

// ----- design/bciu_front.sv -----
// ----------------------------------------------------------------------------
// bciu_front
// Accepts instruction requests and decodes them into the instruction queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bciu_front import bciu_pkg::*; (
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                  q_ready_i,
  output logic                  q_push_o,
  output dec_t                  q_data_o
);

  logic [3:0] opcode;

  assign opcode          = s_axis_tdata_i[15:12];
  assign s_axis_tready_o = q_ready_i;
  assign q_push_o        = s_axis_tvalid_i & q_ready_i;

  always_comb begin
    q_data_o        = '0;
    q_data_o.op     = OP_ADD;
    q_data_o.r1     = s_axis_tdata_i[11:6];
    q_data_o.r2_imm = s_axis_tdata_i[5:0];
    unique case (opcode) inside
      OP_ADD, OP_SUB, OP_MUL, OP_LDI, OP_AND, OP_OR, OP_SLC, OP_SRC, OP_LB: begin
        q_data_o.op     = op_e'(opcode);
        q_data_o.reg_wr = 1'b1;
      end
      OP_BEQZ, OP_JR, OP_SB: begin
        q_data_o.op = op_e'(opcode);
      end
      default: begin
        q_data_o.bad = 1'b1;
      end
    endcase
  end

endmodule

// ----- design/bciu_queue.sv -----
// ----------------------------------------------------------------------------
// bciu_queue
// Short FIFO of decoded instructions between the front end and execute side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bciu_queue import bciu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  dec_t data_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output dec_t data_o
);

  dec_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != QUEUE_CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  // The depth is a power of two, so the pointers wrap on their own.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/bciu_back.sv -----
// ----------------------------------------------------------------------------
// bciu_back
// Execute side: register file and data memory reads, ALU, write-back, program
// counter, status, and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bciu_back import bciu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  dec_t q_data_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  // Storage
  logic [7:0]              rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0]     rf_ok_q;
  logic [7:0]              dm_mem [DMEM_ENTRIES];
  logic [DMEM_ENTRIES-1:0] dm_ok_q;

  // Read stage
  logic       rs_vld_q;
  dec_t       rs_dec_q;
  logic [7:0] rs_a_q, rs_b_q, rs_m_q;
  logic       rs_a_ok_q, rs_b_ok_q, rs_m_ok_q;

  // Most recent register write and store, for forwarding
  logic               wb_vld_q;
  logic [REG_AW-1:0]  wb_idx_q;
  logic [7:0]         wb_data_q;
  logic               st_vld_q;
  logic [DMEM_AW-1:0] st_addr_q;
  logic [7:0]         st_data_q;

  logic [15:0] pc_q;
  logic        out_vld_q;
  res_t        out_q;

  logic               out_free, x_fire, rs_ready, pop;
  logic [DMEM_AW-1:0] q_daddr, x_daddr;
  logic [7:0]         a, b, m;
  logic [8:0]         sum9;
  logic [15:0]        prod, rot_l, rot_r;
  logic [2:0]         sh;
  logic [7:0]         res;
  logic               fc, fv, fn, fs, fz, nz_en, sv_en;
  logic               br, mw;
  logic [15:0]        npc;
  res_t               x_res;

  assign out_free = ~out_vld_q | out_ready_i;
  assign x_fire   = rs_vld_q & out_free;
  assign rs_ready = ~rs_vld_q | x_fire;
  assign pop      = q_valid_i & rs_ready;
  assign q_pop_o  = pop;

  assign q_daddr = q_data_i.r2_imm[DMEM_AW-1:0];
  assign x_daddr = rs_dec_q.r2_imm[DMEM_AW-1:0];

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Everything older than the item in the read stage was in the arrays when it
  // read them, except possibly the last write, which the forward registers hold.
  always_comb begin
    a = rs_a_ok_q ? rs_a_q : 8'h00;
    if (wb_vld_q && wb_idx_q == rs_dec_q.r1) begin
      a = wb_data_q;
    end
    b = rs_b_ok_q ? rs_b_q : 8'h00;
    if (wb_vld_q && wb_idx_q == rs_dec_q.r2_imm) begin
      b = wb_data_q;
    end
    m = rs_m_ok_q ? rs_m_q : 8'h00;
    if (st_vld_q && st_addr_q == x_daddr) begin
      m = st_data_q;
    end
  end

  assign sum9  = {1'b0, a} + {1'b0, b};
  assign prod  = {8'h00, a} * {8'h00, b};
  assign sh    = rs_dec_q.r2_imm[2:0];
  assign rot_l = {a, a} << sh;
  assign rot_r = {a, a} >> sh;

  always_comb begin
    res   = 8'h00;
    fc    = 1'b0;
    fv    = 1'b0;
    nz_en = 1'b0;
    sv_en = 1'b0;
    br    = 1'b0;
    mw    = 1'b0;
    npc   = pc_q + 16'd1;
    if (!rs_dec_q.bad) begin
      unique case (rs_dec_q.op)
        OP_ADD: begin
          res   = sum9[7:0];
          fc    = sum9[8];
          fv    = ~(a[7] ^ b[7]) & (a[7] ^ sum9[7]);
          nz_en = 1'b1;
          sv_en = 1'b1;
        end
        OP_SUB: begin
          res   = a - b;
          fv    = (a[7] ^ b[7]) & (a[7] ^ res[7]);
          nz_en = 1'b1;
          sv_en = 1'b1;
        end
        OP_MUL: begin
          res   = prod[7:0];
          nz_en = 1'b1;
        end
        OP_LDI: begin
          res = {{2{rs_dec_q.r2_imm[5]}}, rs_dec_q.r2_imm};
        end
        OP_BEQZ: begin
          if (a == 8'h00) begin
            npc = pc_q + 16'd1 + {{10{rs_dec_q.r2_imm[5]}}, rs_dec_q.r2_imm};
            br  = 1'b1;
          end
        end
        OP_AND: begin
          res   = a & b;
          nz_en = 1'b1;
        end
        OP_OR: begin
          res   = a | b;
          nz_en = 1'b1;
        end
        OP_JR: begin
          npc = {a, b};
          br  = 1'b1;
        end
        OP_SLC: begin
          res   = rot_l[15:8];
          nz_en = 1'b1;
        end
        OP_SRC: begin
          res   = rot_r[7:0];
          nz_en = 1'b1;
        end
        OP_LB: begin
          res = m;
        end
        OP_SB: begin
          mw = 1'b1;
        end
        default: begin
          res = 8'h00;
        end
      endcase
    end
    fn = nz_en & res[7];
    fz = nz_en & (res == 8'h00);
    fs = sv_en & (fn ^ fv);

    x_res              = '0;
    x_res.next_pc      = npc;
    x_res.status_flags = {fc, fv, fn, fs, fz};
    x_res.reg_write    = rs_dec_q.reg_wr;
    x_res.reg_index    = rs_dec_q.reg_wr ? rs_dec_q.r1 : '0;
    x_res.reg_data     = rs_dec_q.reg_wr ? res : 8'h00;
    x_res.mem_write    = mw;
    x_res.mem_addr     = (!rs_dec_q.bad && (rs_dec_q.op == OP_LB || rs_dec_q.op == OP_SB))
                         ? rs_dec_q.r2_imm : 6'd0;
    x_res.mem_data     = mw ? a : 8'h00;
    x_res.branch_taken = br;
    x_res.bad_opcode   = rs_dec_q.bad;
  end

  // Arrays and payload registers.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rs_dec_q  <= q_data_i;
      rs_a_q    <= rf_mem[q_data_i.r1];
      rs_b_q    <= rf_mem[q_data_i.r2_imm];
      rs_m_q    <= dm_mem[q_daddr];
      rs_a_ok_q <= rf_ok_q[q_data_i.r1];
      rs_b_ok_q <= rf_ok_q[q_data_i.r2_imm];
      rs_m_ok_q <= dm_ok_q[q_daddr];
    end
    if (x_fire && rs_dec_q.reg_wr) begin
      rf_mem[rs_dec_q.r1] <= res;
      wb_idx_q            <= rs_dec_q.r1;
      wb_data_q           <= res;
    end
    if (x_fire && mw) begin
      dm_mem[x_daddr] <= a;
      st_addr_q       <= x_daddr;
      st_data_q       <= a;
    end
    if (x_fire) begin
      out_q <= x_res;
    end
  end

  // Control state; the valid bits make unwritten entries read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      rf_ok_q   <= '0;
      dm_ok_q   <= '0;
      wb_vld_q  <= 1'b0;
      st_vld_q  <= 1'b0;
      pc_q      <= '0;
    end else begin
      if (rs_ready) begin
        rs_vld_q <= q_valid_i;
      end
      if (x_fire) begin
        out_vld_q <= 1'b1;
        pc_q      <= npc;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (x_fire && rs_dec_q.reg_wr) begin
        rf_ok_q[rs_dec_q.r1] <= 1'b1;
        wb_vld_q             <= 1'b1;
      end
      if (x_fire && mw) begin
        dm_ok_q[x_daddr] <= 1'b1;
        st_vld_q         <= 1'b1;
      end
    end
  end

endmodule

// ----- design/byte_cpu_instruction_executor_unit.sv -----
// ----------------------------------------------------------------------------
// byte_cpu_instruction_executor_unit
// 8-bit register machine executing one 16-bit instruction per request.
//
// Channel  | Dir | Signals                      | Contents
// ---------+-----+------------------------------+-------------------------------
// s_axis   | in  | tvalid tready tdata[15:0]    | instr_word
// m_axis   | out | tvalid tready tdata[55:0]    | next_pc, status, reg and mem
//          |     | tuser[3:0]                   | reg/mem write, branch, bad op
//
// One instruction per cycle sustained while the output is not stalled; a request
// passes through the queue, the operand read stage and the execute stage into the
// output register. The execute stage forwards the last register write and the
// last store. Reset clears the queue, pipeline, program counter and the valid
// bits of the register file and data memory.
// A stalled output holds the execute stage; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_cpu_instruction_executor_unit_defines.svh"

module byte_cpu_instruction_executor_unit import bciu_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] instr_word
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] next_pc, [20:16] status_flags, [26:21] reg_index, [34:27] reg_data,
  // [40:35] mem_addr, [48:41] mem_data, [55:49] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] reg_write, [1] mem_write, [2] branch_taken, [3] bad_opcode
  output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  logic q_ready, q_push, q_valid, q_pop;
  dec_t q_in, q_out;
  res_t res;
  logic bad_seen, bad_quiet, st_seen, st_only, nowr_seen, nowr_zero, out_stall;

  bciu_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .q_ready_i       (q_ready),
    .q_push_o        (q_push),
    .q_data_o        (q_in)
  );

  bciu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  bciu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {7'd0, res.mem_data, res.mem_addr, res.reg_data, res.reg_index,
                         res.status_flags, res.next_pc};
  assign m_axis_tuser = {res.bad_opcode, res.branch_taken, res.mem_write, res.reg_write};

  assign bad_seen  = m_axis_tvalid && res.bad_opcode;
  assign bad_quiet = !res.reg_write && !res.mem_write && !res.branch_taken &&
                     (res.status_flags == 5'd0);
  assign st_seen   = m_axis_tvalid && res.mem_write;
  assign st_only   = !res.reg_write && !res.branch_taken;
  assign nowr_seen = m_axis_tvalid && !res.reg_write;
  assign nowr_zero = (res.reg_index == '0) && (res.reg_data == 8'sd0);
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // An invalid opcode leaves every state element but the program counter alone.
  `BCIU_ASSERT_IMP(a_bad_op_quiet, bad_seen, bad_quiet, "invalid opcode had a side effect")

  // A store never writes the register file and never branches.
  `BCIU_ASSERT_IMP(a_store_exclusive, st_seen, st_only, "store also wrote a register or branched")

  // With no register write, the register fields of the result read as zero.
  `BCIU_ASSERT_IMP(a_no_wr_zero, nowr_seen, nowr_zero, "register fields nonzero without a write")

  // A result held under backpressure keeps its program counter.
  `BCIU_ASSERT_NXT(a_pc_hold, out_stall, $stable(res.next_pc), "next_pc moved under a stall")

endmodule
